// File: src/ssra_pkg.sv
// Shared types and constants of the segmented staging ring allocator.
// Used by the remainder unit, the controller, the datapath and the top level; no dependencies.
package ssra_pkg;

   localparam int MAX_SEGMENTS = 8;
   localparam int SEG_W        = 3;
   localparam int CNT_W        = 4;
   localparam int CAP_W        = 33;
   localparam int SIZE_W       = 32;
   localparam int ALIGN_W      = 17;
   localparam int DIV_STEPS    = CAP_W;
   localparam int DIV_CNT_W    = 6;

   localparam logic [CAP_W-1:0] SEG_GRAIN = 33'h0_0001_0000;
   localparam logic [CNT_W-1:0] MIN_SEGS  = 4'd2;
   localparam logic [CNT_W-1:0] MAX_SEGS  = 4'd8;

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_SUBMIT = 2'd1;
   localparam logic [1:0] MODE_WAIT   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_NOFIT   = 2'd2;

   localparam logic CSR_SEG_SIZE = 1'b0;
   localparam logic CSR_MAX_SEGS = 1'b1;

   typedef struct packed {
      logic load;
      logic div_start;
      logic latch_align;
      logic scan_init;
      logic scan_step;
      logic take;
      logic grow;
      logic reclaim;
      logic place;
      logic fail;
      logic zero;
      logic submit;
      logic clear_all;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       size_zero;
      logic       cur_sub;
      logic       fit;
      logic       hit_recyc;
      logic       hit_clean;
      logic       last;
      logic       can_grow;
      logic       advanced;
      logic       div_done;
   } sts_type;

endpackage

// File: src/ssra_rem.sv
// Bit-serial remainder unit: one dividend bit per cycle.
// Depends on ssra_pkg for widths.
module ssra_rem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ssra_pkg::CAP_W-1:0]  dividend,
   input  logic [ssra_pkg::ALIGN_W-1:0] divisor,
   output logic                        done,
   output logic [ssra_pkg::ALIGN_W-1:0] rem
);

   logic [ssra_pkg::CAP_W-1:0]     shift_ff, shift_in;
   logic [ssra_pkg::ALIGN_W-1:0]   rem_ff, rem_in;
   logic [ssra_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic [ssra_pkg::ALIGN_W:0]     trial;

   always_comb begin
      trial    = {rem_ff, shift_ff[ssra_pkg::CAP_W-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[ssra_pkg::CAP_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = ssra_pkg::ALIGN_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[ssra_pkg::ALIGN_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ssra_pkg::DIV_CNT_W'(ssra_pkg::DIV_STEPS - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done = !run_ff && !start;
   assign rem  = rem_ff;

endmodule

// File: src/ssra_ctrl.sv
// Controller state machine of the staging ring allocator.
// Depends on ssra_pkg; drives the datapath by commands and reads its status.
module ssra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output ssra_pkg::cmd_type cmd,
   input  ssra_pkg::sts_type sts
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_DECODE = 10'b00_0000_0010,
      S_DIVGO  = 10'b00_0000_0100,
      S_DIV    = 10'b00_0000_1000,
      S_CHECK  = 10'b00_0001_0000,
      S_SCAN   = 10'b00_0010_0000,
      S_RECL   = 10'b00_0100_0000,
      S_SUBMIT = 10'b00_1000_0000,
      S_CLEAR  = 10'b01_0000_0000,
      S_RESP   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      after_adv;

   always_comb begin
      after_adv = 1'b0;
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (sts.mode == ssra_pkg::MODE_ALLOC) begin
               if (sts.size_zero) begin
                  cmd.zero = 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = S_DIVGO;
               end
            end else if (sts.mode == ssra_pkg::MODE_SUBMIT) begin
               if (sts.cur_sub) begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end else begin
                  state_in = S_SUBMIT;
               end
            end else if (sts.mode == ssra_pkg::MODE_WAIT) begin
               state_in = S_CLEAR;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.latch_align = 1'b1;
               state_in        = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.advanced && (sts.cur_sub || !sts.fit)) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else if (sts.fit) begin
               cmd.place = 1'b1;
               state_in  = S_RESP;
            end else begin
               cmd.fail = 1'b1;
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (sts.hit_recyc) begin
               cmd.take  = 1'b1;
               after_adv = 1'b1;
            end else if (sts.last) begin
               if (sts.can_grow) begin
                  cmd.grow  = 1'b1;
                  after_adv = 1'b1;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_RECL;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_RECL: begin
            if (sts.hit_clean || sts.last) begin
               cmd.reclaim = 1'b1;
               after_adv   = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SUBMIT: begin
            cmd.submit = 1'b1;
            state_in   = S_RESP;
         end
         S_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (after_adv) begin
         state_in = (sts.mode == ssra_pkg::MODE_ALLOC) ? S_DIVGO : S_SUBMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// File: src/ssra_dp.sv
// Datapath of the staging ring allocator: segment table, scan index,
// alignment, configuration registers and result registers.
// Depends on ssra_pkg and ssra_rem.
module ssra_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [ssra_pkg::CAP_W-1:0]      csr_wdata,
   input  logic [1:0]                      req_mode,
   input  logic [ssra_pkg::SIZE_W-1:0]     req_size,
   input  logic [ssra_pkg::ALIGN_W-1:0]    req_alignment,
   input  logic [ssra_pkg::MAX_SEGMENTS-1:0] req_fence_done,
   input  ssra_pkg::cmd_type               cmd,
   output ssra_pkg::sts_type               sts,
   output logic [1:0]                      rsp_status,
   output logic [ssra_pkg::SEG_W-1:0]      rsp_segment,
   output logic [ssra_pkg::CAP_W-1:0]      rsp_offset,
   output logic                            rsp_grew,
   output logic                            rsp_stalled
);

   localparam int NS = ssra_pkg::MAX_SEGMENTS;
   localparam int CW = ssra_pkg::CAP_W;
   localparam int SW = ssra_pkg::SEG_W;
   localparam int KW = ssra_pkg::CNT_W;

   logic [CW-1:0] seg_size_ff, seg_size_in;
   logic [KW-1:0] max_segs_ff, max_segs_in;

   logic [CW-1:0] cap_ff [NS];
   logic [CW-1:0] off_ff [NS];
   logic [CW-1:0] off_in [NS];
   logic [NS-1:0] dirty_ff, dirty_in, sub_ff, sub_in;
   logic [SW-1:0] guard_ff [NS];
   logic [SW-1:0] guard_in [NS];
   logic [KW-1:0] count_ff, count_in;
   logic [SW-1:0] cur_ff, cur_in;

   logic [1:0]                 mode_ff;
   logic [ssra_pkg::SIZE_W-1:0] size_ff;
   logic [ssra_pkg::ALIGN_W-1:0] align_ff;
   logic [NS-1:0]              done_ff;

   logic [SW-1:0] idx_ff, idx_in;
   logic [KW-1:0] scnt_ff, scnt_in;
   logic [CW:0]   aligned_ff, aligned_in;
   logic          adv_ff, adv_in;

   logic [1:0]    status_ff, status_in;
   logic [CW-1:0] offset_ff, offset_in;
   logic          grew_ff, grew_in, stall_ff, stall_in;

   logic [CW-1:0] eff_size, cap_cur, grow_cap, round_size;
   logic [KW-1:0] eff_max;
   logic [SW-1:0] next1, idx_next, pick, grow_idx;
   logic          div_done;
   logic [ssra_pkg::ALIGN_W-1:0] rem;
   logic [CW+1:0] need;

   function automatic logic [ssra_pkg::CAP_W-1:0] req_size_round(
      input logic [ssra_pkg::SIZE_W-1:0] s);
      logic [ssra_pkg::SIZE_W:0] t;
      t = {1'b0, s} + 33'h0_0000_FFFF;
      return {t[ssra_pkg::SIZE_W:16], 16'h0000};
   endfunction

   ssra_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (off_ff[cur_ff]),
      .divisor  (align_ff),
      .done     (div_done),
      .rem      (rem)
   );

   always_comb begin
      eff_size = (seg_size_ff < ssra_pkg::SEG_GRAIN) ? ssra_pkg::SEG_GRAIN : seg_size_ff;
      eff_max  = max_segs_ff;
      if (max_segs_ff < ssra_pkg::MIN_SEGS) begin
         eff_max = ssra_pkg::MIN_SEGS;
      end else if (max_segs_ff > ssra_pkg::MAX_SEGS) begin
         eff_max = ssra_pkg::MAX_SEGS;
      end
      cap_cur    = (cur_ff == '0) ? eff_size : cap_ff[cur_ff];
      round_size = (mode_ff == ssra_pkg::MODE_ALLOC) ? req_size_round(size_ff) : '0;
      grow_cap   = (round_size > eff_size) ? round_size : eff_size;
      next1      = ({1'b0, cur_ff} + 1'b1 == count_ff) ? '0 : cur_ff + 1'b1;
      idx_next   = ({1'b0, idx_ff} + 1'b1 == count_ff) ? '0 : idx_ff + 1'b1;
      grow_idx   = count_ff[SW-1:0];
      need       = {1'b0, aligned_ff} + {2'b0, 1'b0, size_ff};
   end

   always_comb begin
      sts.mode      = mode_ff;
      sts.size_zero = (size_ff == '0);
      sts.cur_sub   = sub_ff[cur_ff];
      sts.fit       = (need <= {2'b0, cap_cur});
      sts.hit_clean = !dirty_ff[idx_ff];
      sts.hit_recyc = !dirty_ff[idx_ff] && (!sub_ff[idx_ff] || done_ff[guard_ff[idx_ff]]);
      sts.last      = (scnt_ff == count_ff);
      sts.can_grow  = (count_ff < eff_max);
      sts.advanced  = adv_ff;
      sts.div_done  = div_done;
   end

   always_comb begin
      seg_size_in = seg_size_ff;
      max_segs_in = max_segs_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ssra_pkg::CSR_SEG_SIZE: seg_size_in = csr_wdata;
            ssra_pkg::CSR_MAX_SEGS: max_segs_in = csr_wdata[KW-1:0];
            default: ;
         endcase
      end

      off_in    = off_ff;
      dirty_in  = dirty_ff;
      sub_in    = sub_ff;
      guard_in  = guard_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      scnt_in   = scnt_ff;
      adv_in    = adv_ff;
      status_in = status_ff;
      offset_in = offset_ff;
      grew_in   = grew_ff;
      stall_in  = stall_ff;
      aligned_in = aligned_ff;
      pick      = sts.hit_clean ? idx_ff : next1;

      if (cmd.load) begin
         adv_in    = 1'b0;
         status_in = ssra_pkg::ST_OK;
         offset_in = '0;
         grew_in   = 1'b0;
         stall_in  = 1'b0;
      end
      if (cmd.latch_align) begin
         if (align_ff <= 17'd1 || rem == '0) begin
            aligned_in = {1'b0, off_ff[cur_ff]};
         end else begin
            aligned_in = {1'b0, off_ff[cur_ff]} + {17'b0, align_ff} - {17'b0, rem};
         end
      end
      if (cmd.scan_init) begin
         idx_in  = next1;
         scnt_in = 4'd1;
      end
      if (cmd.scan_step) begin
         idx_in  = idx_next;
         scnt_in = scnt_ff + 1'b1;
      end
      if (cmd.take) begin
         if (sub_ff[idx_ff]) begin
            sub_in[idx_ff]   = 1'b0;
            guard_in[idx_ff] = idx_ff;
            off_in[idx_ff]   = '0;
         end
         cur_in = idx_ff;
         adv_in = 1'b1;
      end
      if (cmd.grow) begin
         sub_in[grow_idx]   = 1'b0;
         dirty_in[grow_idx] = 1'b0;
         guard_in[grow_idx] = grow_idx;
         off_in[grow_idx]   = '0;
         count_in = count_ff + 1'b1;
         cur_in   = grow_idx;
         grew_in  = 1'b1;
         adv_in   = 1'b1;
      end
      if (cmd.reclaim) begin
         sub_in[pick]   = 1'b0;
         dirty_in[pick] = 1'b0;
         guard_in[pick] = pick;
         off_in[pick]   = '0;
         cur_in   = pick;
         stall_in = 1'b1;
         adv_in   = 1'b1;
      end
      if (cmd.place) begin
         off_in[cur_ff]   = need[CW-1:0];
         dirty_in[cur_ff] = 1'b1;
         offset_in = aligned_ff[CW-1:0];
      end
      if (cmd.fail) begin
         status_in = ssra_pkg::ST_NOFIT;
      end
      if (cmd.zero) begin
         status_in = ssra_pkg::ST_ZERO;
      end
      if (cmd.submit) begin
         for (int i = 0; i < NS; i++) begin
            if (KW'(i) < count_ff && dirty_ff[i]) begin
               dirty_in[i] = 1'b0;
               sub_in[i]   = 1'b1;
               guard_in[i] = cur_ff;
            end
         end
         if (!sub_ff[cur_ff]) begin
            sub_in[cur_ff]   = 1'b1;
            guard_in[cur_ff] = cur_ff;
         end
      end
      if (cmd.clear_all) begin
         for (int i = 0; i < NS; i++) begin
            if (KW'(i) < count_ff) begin
               dirty_in[i] = 1'b0;
               sub_in[i]   = 1'b0;
               guard_in[i] = SW'(i);
               off_in[i]   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_size_ff <= ssra_pkg::SEG_GRAIN;
         max_segs_ff <= 4'd4;
         dirty_ff    <= '0;
         sub_ff      <= '0;
         count_ff    <= 4'd1;
         cur_ff      <= '0;
         for (int i = 0; i < NS; i++) begin
            off_ff[i]   <= '0;
            guard_ff[i] <= SW'(i);
         end
      end else begin
         seg_size_ff <= seg_size_in;
         max_segs_ff <= max_segs_in;
         dirty_ff    <= dirty_in;
         sub_ff      <= sub_in;
         count_ff    <= count_in;
         cur_ff      <= cur_in;
         off_ff      <= off_in;
         guard_ff    <= guard_in;
      end
      if (cmd.grow) begin
         cap_ff[grow_idx] <= grow_cap;
      end
      if (cmd.load) begin
         mode_ff  <= req_mode;
         size_ff  <= req_size;
         align_ff <= req_alignment;
         done_ff  <= req_fence_done;
      end
      idx_ff     <= idx_in;
      scnt_ff    <= scnt_in;
      adv_ff     <= adv_in;
      aligned_ff <= aligned_in;
      status_ff  <= status_in;
      offset_ff  <= offset_in;
      grew_ff    <= grew_in;
      stall_ff   <= stall_in;
   end

   assign rsp_status  = status_ff;
   assign rsp_segment = cur_ff;
   assign rsp_offset  = offset_ff;
   assign rsp_grew    = grew_ff;
   assign rsp_stalled = stall_ff;

endmodule

// File: src/segmented_staging_ring_allocator.sv
// Top level of the segmented staging ring allocator.
// Depends on ssra_pkg, ssra_ctrl and ssra_dp.
//
// One request is taken when start is high and busy is low; its single result
// beat appears on the rsp_ ports for one cycle with rsp_valid, and the
// receiver cannot stall it. A zero-size allocate or an unused mode goes from
// decode straight to the result beat; a wait-all first clears the used segments.
// An allocate runs the bit-serial alignment remainder unit and gives its
// result when it fits in the current, unsubmitted segment; otherwise a scan
// for another segment (one segment per cycle) and a second alignment pass
// follow. A submit first scans for another segment when the current one is
// already submitted. Busy drops in the cycle after the result beat, when the
// next request can be taken. Configuration writes take effect at the next
// edge and belong between requests.
module segmented_staging_ring_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [ssra_pkg::CAP_W-1:0]        csr_wdata,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_mode,
   input  logic [ssra_pkg::SIZE_W-1:0]       req_size,
   input  logic [ssra_pkg::ALIGN_W-1:0]      req_alignment,
   input  logic [ssra_pkg::MAX_SEGMENTS-1:0] req_fence_done,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [ssra_pkg::SEG_W-1:0]        rsp_segment,
   output logic [ssra_pkg::CAP_W-1:0]        rsp_offset,
   output logic                              rsp_grew,
   output logic                              rsp_stalled
);

   ssra_pkg::cmd_type cmd;
   ssra_pkg::sts_type sts;

   ssra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   ssra_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_mode       (req_mode),
      .req_size       (req_size),
      .req_alignment  (req_alignment),
      .req_fence_done (req_fence_done),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_status     (rsp_status),
      .rsp_segment    (rsp_segment),
      .rsp_offset     (rsp_offset),
      .rsp_grew       (rsp_grew),
      .rsp_stalled    (rsp_stalled)
   );

endmodule
